### hw/rtl/ceb_pkg.sv
// Shared types and constants of the coincidence event builder.
package ceb_pkg;

  // Field widths
  localparam int unsigned TS_W     = 48;
  localparam int unsigned EVT_W    = 48;
  localparam int unsigned IDX_W    = 6;
  localparam int unsigned BOARD_W  = 8;
  localparam int unsigned WORD_W   = 16;
  localparam int unsigned CHAN_W   = 6;
  localparam int unsigned WINDOW_W = 31;

  // Request codes
  localparam logic REQ_HIT   = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  // Coincidence window after reset
  localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(100);

  // One buffered hit as held in the event store
  typedef struct packed {
    logic [TS_W-1:0]    timestamp;
    logic [WORD_W-1:0]  short_energy;
    logic [WORD_W-1:0]  energy;
    logic [CHAN_W-1:0]  channel;
    logic [WORD_W-1:0]  serial_number;
    logic [BOARD_W-1:0] board_id;
    logic [WORD_W-1:0]  flags_high;
    logic [WORD_W-1:0]  flags_low;
    logic [WORD_W-1:0]  fine_time;
  } hit_entry_t;

endpackage

### hw/rtl/ceb_if.sv
// Channel interfaces: hit input, result output and window configuration.
interface ceb_hit_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [ceb_pkg::BOARD_W-1:0]   board_id;
  logic [ceb_pkg::WORD_W-1:0]    serial_number;
  logic [ceb_pkg::CHAN_W-1:0]    channel;
  logic [ceb_pkg::WORD_W-1:0]    energy;
  logic [ceb_pkg::WORD_W-1:0]    short_energy;
  logic [ceb_pkg::TS_W-1:0]      timestamp;
  logic [ceb_pkg::WORD_W-1:0]    fine_time;
  logic [ceb_pkg::WORD_W-1:0]    flags_low;
  logic [ceb_pkg::WORD_W-1:0]    flags_high;

  modport source (
    output valid, req_type, board_id, serial_number, channel, energy, short_energy,
           timestamp, fine_time, flags_low, flags_high,
    input  ready
  );
  modport sink (
    input  valid, req_type, board_id, serial_number, channel, energy, short_energy,
           timestamp, fine_time, flags_low, flags_high,
    output ready
  );
endinterface

interface ceb_res_if;
  logic                          valid;
  logic                          ready;
  logic [ceb_pkg::EVT_W-1:0]     event_number;
  logic [ceb_pkg::IDX_W-1:0]     hit_index;
  logic [ceb_pkg::BOARD_W-1:0]   out_board;
  logic [ceb_pkg::WORD_W-1:0]    out_serial;
  logic [ceb_pkg::CHAN_W-1:0]    out_channel;
  logic [ceb_pkg::WORD_W-1:0]    out_energy;
  logic [ceb_pkg::WORD_W-1:0]    out_short_energy;
  logic [ceb_pkg::TS_W-1:0]      out_timestamp;
  logic [ceb_pkg::WORD_W-1:0]    out_fine_time;
  logic [ceb_pkg::WORD_W-1:0]    out_flags_low;
  logic [ceb_pkg::WORD_W-1:0]    out_flags_high;
  logic                          last_of_event;

  modport source (
    output valid, event_number, hit_index, out_board, out_serial, out_channel,
           out_energy, out_short_energy, out_timestamp, out_fine_time,
           out_flags_low, out_flags_high, last_of_event,
    input  ready
  );
  modport sink (
    input  valid, event_number, hit_index, out_board, out_serial, out_channel,
           out_energy, out_short_energy, out_timestamp, out_fine_time,
           out_flags_low, out_flags_high, last_of_event,
    output ready
  );
endinterface

interface ceb_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ceb_pkg::WINDOW_W-1:0]   time_window;

  modport source (output valid, time_window, input ready);
  modport sink   (input valid, time_window, output ready);
endinterface

### hw/rtl/coincidence_event_builder.sv
// Top level of the time-window coincidence event builder.
//
//  Port     Dir   Transfer carries
//  in_ch    in    one hit, or a flush request (req_type)
//  out_ch   out   one buffered hit tagged with event number, index and last flag
//  cfg_ch   in    coincidence window (time_window), always ready
//
//  A hit that joins the open event, or opens one, is written straight into the store.
//  A flush that closes an event of n hits reads the store once per result, in
//  order from slot 0; a closing hit is held, then written into slot 0 after the drain.
//  in_ch is not ready while an event drains or the held hit is written.
//  out_ch stalls hold the read data and pause the drain.
//  Synchronous reset, no clearing pass: the store is only read below the count.
module coincidence_event_builder #(
  parameter int unsigned EVENT_DEPTH = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  ceb_hit_if.sink      in_ch,
  ceb_res_if.source    out_ch,
  ceb_cfg_if.sink      cfg_ch
);

  localparam int unsigned AW = $clog2(EVENT_DEPTH);
  localparam int unsigned CW = $clog2(EVENT_DEPTH + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DRAIN = 2'd1;
  localparam logic [1:0] ST_LOAD  = 2'd2;

  logic [1:0]                     state_r, state_nxt;
  logic [CW-1:0]                  count_r, count_nxt;
  logic [AW-1:0]                  rd_idx_r, rd_idx_nxt;
  logic [ceb_pkg::TS_W-1:0]       first_time_r, first_time_nxt;
  logic [ceb_pkg::EVT_W-1:0]      evt_cnt_r, evt_cnt_nxt;
  logic                           pend_r, pend_nxt;
  ceb_pkg::hit_entry_t            hold_r, hold_nxt;
  logic [ceb_pkg::WINDOW_W-1:0]   window_r;
  logic                           out_valid_r, out_valid_nxt;
  logic [ceb_pkg::EVT_W-1:0]      tag_evt_r;
  logic [ceb_pkg::IDX_W-1:0]      tag_idx_r;
  logic                           tag_last_r;

  ceb_pkg::hit_entry_t            in_entry, wr_data, rd_data;
  logic                           wr_en, rd_en, rd_last;
  logic [AW-1:0]                  wr_addr;
  logic                           in_xfer, joins;
  logic [ceb_pkg::TS_W-1:0]       diff;

  // Incoming hit as a store entry
  always_comb begin
    in_entry.timestamp     = in_ch.timestamp;
    in_entry.short_energy  = in_ch.short_energy;
    in_entry.energy        = in_ch.energy;
    in_entry.channel       = in_ch.channel;
    in_entry.serial_number = in_ch.serial_number;
    in_entry.board_id      = in_ch.board_id;
    in_entry.flags_high    = in_ch.flags_high;
    in_entry.flags_low     = in_ch.flags_low;
    in_entry.fine_time     = in_ch.fine_time;
  end

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;

  // Window test, modulo 2^48, plus the full-buffer close
  assign diff  = in_ch.timestamp - first_time_r;
  assign joins = (diff < {{(ceb_pkg::TS_W - ceb_pkg::WINDOW_W){1'b0}}, window_r}) &&
                 (count_r < CW'(EVENT_DEPTH));

  // Store reads pace with the output register
  assign rd_en   = (state_r == ST_DRAIN) && (!out_valid_r || out_ch.ready);
  assign rd_last = ((CW'(rd_idx_r) + CW'(1)) == count_r);

  // Control
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    rd_idx_nxt     = rd_idx_r;
    first_time_nxt = first_time_r;
    evt_cnt_nxt    = evt_cnt_r;
    pend_nxt       = pend_r;
    hold_nxt       = hold_r;
    wr_en          = 1'b0;
    wr_addr        = count_r[AW-1:0];
    wr_data        = in_entry;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_ch.req_type == ceb_pkg::REQ_FLUSH) begin
            if (count_r != '0) begin
              pend_nxt   = 1'b0;
              rd_idx_nxt = '0;
              state_nxt  = ST_DRAIN;
            end
          end else if (count_r == '0) begin
            wr_en          = 1'b1;
            wr_addr        = '0;
            first_time_nxt = in_ch.timestamp;
            count_nxt      = CW'(1);
          end else if (joins) begin
            wr_en     = 1'b1;
            count_nxt = count_r + CW'(1);
          end else begin
            hold_nxt   = in_entry;
            pend_nxt   = 1'b1;
            rd_idx_nxt = '0;
            state_nxt  = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (rd_en) begin
          if (rd_last) begin
            rd_idx_nxt  = '0;
            count_nxt   = '0;
            evt_cnt_nxt = evt_cnt_r + ceb_pkg::EVT_W'(1);
            state_nxt   = pend_r ? ST_LOAD : ST_IDLE;
          end else begin
            rd_idx_nxt = rd_idx_r + AW'(1);
          end
        end
      end
      ST_LOAD: begin
        // held hit opens the next event
        wr_en          = 1'b1;
        wr_addr        = '0;
        wr_data        = hold_r;
        first_time_nxt = hold_r.timestamp;
        count_nxt      = CW'(1);
        pend_nxt       = 1'b0;
        state_nxt      = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (rd_en) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      rd_idx_r     <= '0;
      first_time_r <= '0;
      evt_cnt_r    <= '0;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      window_r     <= ceb_pkg::WINDOW_RESET;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      rd_idx_r     <= rd_idx_nxt;
      first_time_r <= first_time_nxt;
      evt_cnt_r    <= evt_cnt_nxt;
      pend_r       <= pend_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_ch.valid) begin
        window_r <= cfg_ch.time_window;
      end
    end
  end

  // Payload registers: held hit and result tags
  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
    if (rd_en) begin
      tag_evt_r  <= evt_cnt_r;
      tag_idx_r  <= ceb_pkg::IDX_W'(rd_idx_r);
      tag_last_r <= rd_last;
    end
  end

  assign cfg_ch.ready = 1'b1;

  ceb_event_store #(
    .DEPTH (EVENT_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_idx_r),
    .rd_data (rd_data)
  );

  // Result channel straight from the store read register
  assign out_ch.valid            = out_valid_r;
  assign out_ch.event_number     = tag_evt_r;
  assign out_ch.hit_index        = tag_idx_r;
  assign out_ch.last_of_event    = tag_last_r;
  assign out_ch.out_board        = rd_data.board_id;
  assign out_ch.out_serial       = rd_data.serial_number;
  assign out_ch.out_channel      = rd_data.channel;
  assign out_ch.out_energy       = rd_data.energy;
  assign out_ch.out_short_energy = rd_data.short_energy;
  assign out_ch.out_timestamp    = rd_data.timestamp;
  assign out_ch.out_fine_time    = rd_data.fine_time;
  assign out_ch.out_flags_low    = rd_data.flags_low;
  assign out_ch.out_flags_high   = rd_data.flags_high;

  // Checks
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(EVENT_DEPTH))
    else $error("hit count beyond buffer depth");

  a_one_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && rd_en))
    else $error("store read and write in the same cycle");

  a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |-> (count_r != '0))
    else $error("draining an empty event");

  a_evt_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && rd_last) |=> (evt_cnt_r == $past(evt_cnt_r) + ceb_pkg::EVT_W'(1)))
    else $error("event number did not advance after last read");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !rd_en)
    else $error("stalled result overwritten");

endmodule

### hw/rtl/ceb_event_store.sv
// Event store with separate write and read ports: one write and one registered read per cycle.
module ceb_event_store #(
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  ceb_pkg::hit_entry_t wr_data,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  output ceb_pkg::hit_entry_t rd_data
);

  ceb_pkg::hit_entry_t mem [DEPTH];
  ceb_pkg::hit_entry_t rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
